FILE: design/pcg_pkg.sv
package pcg_pkg;

	// lcg multiplier and reset values
	localparam logic [63:0] PCG_MULT       = 64'd6364136223846793005;
	localparam logic [63:0] PCG_STATE_INIT = 64'h853c49e6748fea9b;
	localparam logic [63:0] PCG_INC_INIT   = 64'hda3e39cb94b95bdb;

	// xorshift and rotate positions
	localparam int XSH_SHIFT  = 18;
	localparam int XSH_OUT    = 27;
	localparam int ROT_SHIFT  = 59;

	// configuration register indexes
	localparam int          CFG_IDX_W      = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_STATE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_SEQ   = 1'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_THR,
		ST_DRAW,
		ST_MUL,
		ST_MOD,
		ST_OUT,
		ST_RS_STEP1,
		ST_RS_WAIT1,
		ST_RS_ADD,
		ST_RS_STEP2,
		ST_RS_WAIT2
	} pcg_state_t;

	// output permutation: xorshift high, then rotate right by top five bits
	function automatic logic [31:0] xsh_rr(input logic [63:0] old);
		logic [63:0] mix;
		logic [31:0] xs;
		logic [4:0]  rot;
		logic [63:0] dbl;
		mix = (old >> XSH_SHIFT) ^ old;
		xs  = mix[XSH_OUT +: 32];
		rot = old[ROT_SHIFT +: 5];
		dbl = {xs, xs} >> rot;
		return dbl[31:0];
	endfunction

endpackage

FILE: design/pcg32_random_generator_top.sv
// pcg32 xsh-rr random number generator
// input channel (in_valid/in_ready, bound): one request item per result.
//   a bound of zero returns the raw 32-bit output; otherwise values are
//   drawn until one reaches (2^32 - bound) mod bound, and that value
//   mod bound is returned
// output channel (out_valid/out_ready, value): one item per request
// config channel (cfg_valid/cfg_ready, cfg_index, cfg_data):
//   index 0 stores seed_state, index 1 reseeds from seed_seq and seed_state
// one 32x32 multiplier, used three times, advances the 64-bit lcg state;
//   one radix-2 divider produces each remainder
// a zero bound draws once and loads the output; a nonzero bound computes the
//   threshold, draws until accepted, takes the final remainder, loads the output
// one request at a time: in_ready and cfg_ready are high only when idle
// reset loads the fixed default state and increment, no reseed happens
// the output register frees the core: a new request can be taken while
//   a result waits; a stalled receiver only holds the next result back
module pcg32_random_generator_top
	import pcg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          bound,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          value,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	pcg_state_t  state_q, state_d;

	// architectural state
	logic [63:0] lcg_q;
	logic [63:0] inc_q;
	logic [63:0] seed_state_q;

	// per-request registers
	logic [31:0] bound_q;
	logic [31:0] thr_q;
	logic [31:0] r_q;
	logic [31:0] res_q;

	// output register
	logic        out_valid_q;
	logic [31:0] value_q;

	logic        in_fire;
	logic        cfg_fire;
	logic        out_load;

	// shared unit controls
	logic        mul_start;
	logic        mul_done;
	logic [63:0] mul_prod;
	logic        div_start;
	logic [31:0] div_dividend;
	logic [31:0] div_divisor;
	logic        div_done;
	logic [31:0] div_rem;

	assign cfg_ready = (state_q == ST_IDLE);
	// a config write wins over a request in the same cycle
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign in_fire   = in_valid && in_ready;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// sequencer
	always_comb begin
		state_d      = state_q;
		mul_start    = 1'b0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		out_load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cfg_fire && (cfg_index == CFG_SEED_SEQ)) begin
					state_d = ST_RS_STEP1;
				end else if (in_fire) begin
					if (bound == 32'd0) begin
						state_d = ST_DRAW;
					end else begin
						// threshold = (2^32 - bound) mod bound
						div_start    = 1'b1;
						div_dividend = 32'd0 - bound;
						div_divisor  = bound;
						state_d      = ST_THR;
					end
				end
			end
			ST_THR: begin
				if (div_done) begin
					state_d = ST_DRAW;
				end
			end
			ST_DRAW: begin
				mul_start = 1'b1;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				if (mul_done) begin
					if (bound_q == 32'd0) begin
						state_d = ST_OUT;
					end else if (r_q < thr_q) begin
						// rejected, draw again
						state_d = ST_DRAW;
					end else begin
						div_start    = 1'b1;
						div_dividend = r_q;
						div_divisor  = bound_q;
						state_d      = ST_MOD;
					end
				end
			end
			ST_MOD: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_RS_STEP1: begin
				mul_start = 1'b1;
				state_d   = ST_RS_WAIT1;
			end
			ST_RS_WAIT1: begin
				if (mul_done) begin
					state_d = ST_RS_ADD;
				end
			end
			ST_RS_ADD: begin
				state_d = ST_RS_STEP2;
			end
			ST_RS_STEP2: begin
				mul_start = 1'b1;
				state_d   = ST_RS_WAIT2;
			end
			ST_RS_WAIT2: begin
				if (mul_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			lcg_q        <= PCG_STATE_INIT;
			inc_q        <= PCG_INC_INIT;
			seed_state_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_fire) begin
				if (cfg_index == CFG_SEED_STATE) begin
					seed_state_q <= cfg_data;
				end else begin
					// reseed: odd increment from the stream selector, state cleared
					inc_q <= {cfg_data[62:0], 1'b1};
					lcg_q <= '0;
				end
			end
			// state advance after each multiply
			if (mul_done) begin
				lcg_q <= mul_prod + inc_q;
			end
			if (state_q == ST_RS_ADD) begin
				lcg_q <= lcg_q + seed_state_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			bound_q <= bound;
		end
		if ((state_q == ST_THR) && div_done) begin
			thr_q <= div_rem;
		end
		// output of the old state, taken as the multiply starts
		if (state_q == ST_DRAW) begin
			r_q <= xsh_rr(lcg_q);
		end
		if ((state_q == ST_MUL) && mul_done && (bound_q == 32'd0)) begin
			res_q <= r_q;
		end
		if ((state_q == ST_MOD) && div_done) begin
			res_q <= div_rem;
		end
		if (out_load) begin
			value_q <= res_q;
		end
	end

	pcg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (lcg_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	pcg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign out_valid = out_valid_q;
	assign value     = value_q;

	// multiplier finishes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_MUL || state_q == ST_RS_WAIT1 ||
			state_q == ST_RS_WAIT2))
		else $error("multiplier done outside a wait state");

	// divider finishes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_THR || state_q == ST_MOD))
		else $error("divider done outside a wait state");

	// the increment stays odd
	assert property (@(posedge clk) disable iff (!arst_n)
		inc_q[0])
		else $error("even lcg increment");

	// a bounded result is below its bound
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && bound_q != 32'd0) |-> (res_q < bound_q))
		else $error("result not below bound");

endmodule

FILE: design/pcg_mul.sv
module pcg_mul
	import pcg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	output logic        done,
	output logic [63:0] prod
);

	logic [63:0] a_q;
	logic [63:0] pp_q;
	logic [63:0] acc_q;
	logic [1:0]  phase_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] opa;
	logic [31:0] opb;

	// low 64 bits of a * mult: lo*lo, then the two cross terms shifted up
	always_comb begin
		opa = (phase_q == 2'd2) ? a_q[63:32] : a_q[31:0];
		opb = (phase_q == 2'd1) ? PCG_MULT[63:32] : PCG_MULT[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 2'd0;
		end else begin
			done_q <= busy_q && (phase_q == 2'd3);
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 2'd0;
			end else if (busy_q) begin
				phase_q <= phase_q + 2'd1;
				if (phase_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
		end
		if (busy_q) begin
			pp_q <= {32'd0, opa} * {32'd0, opb};
			if (phase_q == 2'd1) begin
				acc_q <= pp_q;
			end else if (phase_q != 2'd0) begin
				acc_q <= acc_q + {pp_q[31:0], 32'd0};
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

FILE: design/pcg_div.sv
module pcg_div
	import pcg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] rem
);

	logic [31:0] dvd_q;
	logic [31:0] dsr_q;
	logic [31:0] rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	// restoring division, one quotient bit a cycle, remainder kept
	always_comb begin
		shifted = {rem_q, dvd_q[31]};
		diff    = shifted - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= diff[32] ? shifted[31:0] : diff[31:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
